// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check violated");
`else
`define ASSERT_ALWAYS(name, clk, rst, expr)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/cgntt_pkg.sv =====
// ----------------------------------------------------------------------------
// Constant geometry NTT package
// Sizes, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none

package cgntt_pkg;

   localparam int LENGTH         = 256;
   localparam int HALF_LEN       = LENGTH / 2;
   localparam int STAGE_COUNT    = 8;
   localparam int WORD_BITS      = 32;
   localparam int ADDR_BITS      = $clog2(LENGTH);
   localparam int TW_ADDR_BITS   = $clog2(HALF_LEN);
   localparam int STAGE_BITS     = $clog2(STAGE_COUNT);
   localparam int BIT_CNT_BITS   = $clog2(WORD_BITS);
   localparam int ACTION_BITS    = 2;
   localparam int INDEX_BITS     = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int VARIANT_BITS   = 2;

   localparam logic [WORD_BITS-1:0] MODULUS_RESET   = WORD_BITS'(12289);
   localparam logic [WORD_BITS-1:0] N_INVERSE_RESET = WORD_BITS'(1);
   localparam logic                 FINAL_IN_SCRATCH = ((STAGE_COUNT % 2) == 1);

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_LOAD_COEF,
      ACT_LOAD_TW,
      ACT_RUN,
      ACT_READ
   } action_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODULUS,
      CSR_N_INVERSE,
      CSR_VARIANT,
      CSR_INVERSE_MODE
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAP_IDX,
      OP_RSP_LOAD,
      OP_CAP_UW,
      OP_CAP_U,
      OP_CAP_L,
      OP_RED_U,
      OP_RED_L,
      OP_RED_S,
      OP_MUL_LW,
      OP_MUL_DW,
      OP_MUL_FS,
      OP_ADDSUB_UL,
      OP_ADDSUB_UT
   } dp_op_type;

   typedef enum logic [1:0] {
      WR_LOAD,
      WR_HI,
      WR_LO
   } wr_sel_type;

   typedef enum logic [1:0] {
      DEST_U,
      DEST_L,
      DEST_S,
      DEST_LO
   } unit_dest_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_READ,
      ST_BF_RD_U,
      ST_BF_RD_L,
      ST_BF_CAP_L,
      ST_BF_RED_U,
      ST_BF_WAIT_U,
      ST_BF_RED_L,
      ST_BF_WAIT_L,
      ST_BF_ADDSUB,
      ST_BF_MUL,
      ST_BF_WAIT_M,
      ST_BF_ADDSUB_T,
      ST_BF_WR_HI,
      ST_BF_WR_LO,
      ST_INV_S,
      ST_INV_WAIT_S,
      ST_INV_RD,
      ST_INV_CAP,
      ST_INV_MUL,
      ST_INV_WAIT,
      ST_INV_WR
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type                op;
      logic                     rd_en;
      logic                     rd_scratch;
      logic [ADDR_BITS-1:0]     rd_addr;
      logic                     tw_rd_en;
      logic                     tw_wr_en;
      logic [TW_ADDR_BITS-1:0]  tw_addr;
      logic                     wr_en;
      logic                     wr_scratch;
      logic [ADDR_BITS-1:0]     wr_addr;
      wr_sel_type               wr_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== hdl/cgntt_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one action item.
// ----------------------------------------------------------------------------
`default_nettype none

interface cgntt_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [cgntt_pkg::ACTION_BITS-1:0]    action;
   logic [cgntt_pkg::INDEX_BITS-1:0]     index;
   logic [cgntt_pkg::WORD_BITS-1:0]      value;

   modport source (output valid, action, index, value, input ready);
   modport sink (input valid, action, index, value, output ready);
endinterface

`default_nettype wire

// ===== hdl/cgntt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one read result.
// ----------------------------------------------------------------------------
`default_nettype none

interface cgntt_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [cgntt_pkg::INDEX_BITS-1:0]     result_index;
   logic [cgntt_pkg::WORD_BITS-1:0]      result_value;

   modport source (output valid, result_index, result_value, input ready);
   modport sink (input valid, result_index, result_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/cgntt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cgntt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]          wr_data,
   input  wire logic                      rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/cgntt_ctrl.sv =====
// ----------------------------------------------------------------------------
// NTT controller
// Sequences loads, reads, butterfly stages and the final scaling pass.
// ----------------------------------------------------------------------------
`default_nettype none

module cgntt_ctrl (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [cgntt_pkg::ACTION_BITS-1:0]     req_action,
   input  wire logic [cgntt_pkg::INDEX_BITS-1:0]      req_index,
   input  wire logic [cgntt_pkg::VARIANT_BITS-1:0]    variant,
   input  wire logic                                  inverse_mode,
   input  wire cgntt_pkg::dp_status_type              status,
   output cgntt_pkg::dp_cmd_type                      cmd
);

   localparam int TW = cgntt_pkg::TW_ADDR_BITS;

   function automatic logic [TW-1:0] reverse_tw(input logic [TW-1:0] j);
      logic [TW-1:0] r;
      for (int i = 0; i < TW; i++) begin
         r[i] = j[TW-1-i];
      end
      return r;
   endfunction

   cgntt_pkg::ctrl_state_type                state_ff, state_in;
   logic [cgntt_pkg::STAGE_BITS-1:0]         stage_ff, stage_in;
   logic [cgntt_pkg::ADDR_BITS-1:0]          cnt_ff, cnt_in;
   logic [TW-1:0]                            a_mask_ff, a_mask_in;
   logic [TW-1:0]                            b_mask_ff, b_mask_in;
   logic                                     final_ff, final_in;

   cgntt_pkg::action_type  act;
   logic                   accept;
   logic                   pease, dit, rev;
   logic [TW-1:0]          j;
   logic                   last_j, last_stage, last_entry;
   logic                   fin_group;
   logic [cgntt_pkg::ADDR_BITS-1:0] u_addr, l_addr, hi_addr, lo_addr;
   logic [TW-1:0]          tw_idx;

   assign act        = cgntt_pkg::action_type'(req_action);
   assign req_ready  = (state_ff == cgntt_pkg::ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign pease      = ~variant[1];
   assign dit        = variant[0];
   assign rev        = pease ^ dit;
   assign j          = cnt_ff[TW-1:0];
   assign last_j     = (j == {TW{1'b1}});
   assign last_stage = (stage_ff == cgntt_pkg::STAGE_BITS'(cgntt_pkg::STAGE_COUNT - 1));
   assign last_entry = (cnt_ff == {cgntt_pkg::ADDR_BITS{1'b1}});
   assign u_addr     = pease ? {j, 1'b0} : {1'b0, j};
   assign l_addr     = pease ? {j, 1'b1} : {1'b1, j};
   assign hi_addr    = pease ? {1'b0, j} : {j, 1'b0};
   assign lo_addr    = pease ? {1'b1, j} : {j, 1'b1};
   assign tw_idx     = (rev ? reverse_tw(j) : j) & a_mask_ff;
   assign fin_group  = (state_ff == cgntt_pkg::ST_IDLE) || (state_ff == cgntt_pkg::ST_READ) ||
                       (state_ff == cgntt_pkg::ST_INV_S) || (state_ff == cgntt_pkg::ST_INV_WAIT_S) ||
                       (state_ff == cgntt_pkg::ST_INV_RD) || (state_ff == cgntt_pkg::ST_INV_CAP) ||
                       (state_ff == cgntt_pkg::ST_INV_MUL) || (state_ff == cgntt_pkg::ST_INV_WAIT) ||
                       (state_ff == cgntt_pkg::ST_INV_WR);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cgntt_pkg::ST_IDLE: begin
            if (accept && (act == cgntt_pkg::ACT_RUN)) begin
               state_in = cgntt_pkg::ST_BF_RD_U;
            end else if (accept && (act == cgntt_pkg::ACT_READ)) begin
               state_in = cgntt_pkg::ST_READ;
            end
         end
         cgntt_pkg::ST_READ: begin
            if (status.rsp_free) begin
               state_in = cgntt_pkg::ST_IDLE;
            end
         end
         cgntt_pkg::ST_BF_RD_U:   state_in = cgntt_pkg::ST_BF_RD_L;
         cgntt_pkg::ST_BF_RD_L:   state_in = cgntt_pkg::ST_BF_CAP_L;
         cgntt_pkg::ST_BF_CAP_L:  state_in = cgntt_pkg::ST_BF_RED_U;
         cgntt_pkg::ST_BF_RED_U:  state_in = cgntt_pkg::ST_BF_WAIT_U;
         cgntt_pkg::ST_BF_WAIT_U: begin
            if (!status.busy) begin
               state_in = cgntt_pkg::ST_BF_RED_L;
            end
         end
         cgntt_pkg::ST_BF_RED_L:  state_in = cgntt_pkg::ST_BF_WAIT_L;
         cgntt_pkg::ST_BF_WAIT_L: begin
            if (!status.busy) begin
               state_in = dit ? cgntt_pkg::ST_BF_MUL : cgntt_pkg::ST_BF_ADDSUB;
            end
         end
         cgntt_pkg::ST_BF_ADDSUB: state_in = cgntt_pkg::ST_BF_MUL;
         cgntt_pkg::ST_BF_MUL:    state_in = cgntt_pkg::ST_BF_WAIT_M;
         cgntt_pkg::ST_BF_WAIT_M: begin
            if (!status.busy) begin
               state_in = dit ? cgntt_pkg::ST_BF_ADDSUB_T : cgntt_pkg::ST_BF_WR_HI;
            end
         end
         cgntt_pkg::ST_BF_ADDSUB_T: state_in = cgntt_pkg::ST_BF_WR_HI;
         cgntt_pkg::ST_BF_WR_HI:    state_in = cgntt_pkg::ST_BF_WR_LO;
         cgntt_pkg::ST_BF_WR_LO: begin
            if (last_j && last_stage) begin
               state_in = inverse_mode ? cgntt_pkg::ST_INV_S : cgntt_pkg::ST_IDLE;
            end else begin
               state_in = cgntt_pkg::ST_BF_RD_U;
            end
         end
         cgntt_pkg::ST_INV_S:      state_in = cgntt_pkg::ST_INV_WAIT_S;
         cgntt_pkg::ST_INV_WAIT_S: begin
            if (!status.busy) begin
               state_in = cgntt_pkg::ST_INV_RD;
            end
         end
         cgntt_pkg::ST_INV_RD:  state_in = cgntt_pkg::ST_INV_CAP;
         cgntt_pkg::ST_INV_CAP: state_in = cgntt_pkg::ST_INV_MUL;
         cgntt_pkg::ST_INV_MUL: state_in = cgntt_pkg::ST_INV_WAIT;
         cgntt_pkg::ST_INV_WAIT: begin
            if (!status.busy) begin
               state_in = cgntt_pkg::ST_INV_WR;
            end
         end
         cgntt_pkg::ST_INV_WR: begin
            state_in = last_entry ? cgntt_pkg::ST_IDLE : cgntt_pkg::ST_INV_RD;
         end
         default: state_in = cgntt_pkg::ST_IDLE;
      endcase
   end

   // loop counters and stage masks
   always_comb begin
      stage_in  = stage_ff;
      cnt_in    = cnt_ff;
      a_mask_in = a_mask_ff;
      b_mask_in = b_mask_ff;
      final_in  = final_ff;
      if ((state_ff == cgntt_pkg::ST_IDLE) && accept && (act == cgntt_pkg::ACT_RUN)) begin
         stage_in  = '0;
         cnt_in    = '0;
         a_mask_in = dit ? '0 : {TW{1'b1}};
         b_mask_in = dit ? TW'(cgntt_pkg::LENGTH >> 2) : {TW{1'b1}};
      end else if (state_ff == cgntt_pkg::ST_BF_WR_LO) begin
         if (last_j) begin
            cnt_in = '0;
            if (last_stage) begin
               final_in = cgntt_pkg::FINAL_IN_SCRATCH;
            end else begin
               stage_in = stage_ff + 1'b1;
               if (dit) begin
                  a_mask_in = a_mask_ff | b_mask_ff;
                  b_mask_in = b_mask_ff >> 1;
               end else begin
                  a_mask_in = a_mask_ff << 1;
               end
            end
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (state_ff == cgntt_pkg::ST_INV_WR) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // datapath commands
   always_comb begin
      cmd            = '0;
      cmd.op         = cgntt_pkg::OP_NONE;
      cmd.wr_sel     = cgntt_pkg::WR_LOAD;
      cmd.rd_scratch = fin_group ? final_ff : stage_ff[0];
      unique case (state_ff)
         cgntt_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (act)
                  cgntt_pkg::ACT_LOAD_COEF: begin
                     cmd.wr_en      = 1'b1;
                     cmd.wr_scratch = 1'b0;
                     cmd.wr_addr    = req_index[cgntt_pkg::ADDR_BITS-1:0];
                  end
                  cgntt_pkg::ACT_LOAD_TW: begin
                     cmd.tw_wr_en = 1'b1;
                     cmd.tw_addr  = req_index[TW-1:0];
                  end
                  cgntt_pkg::ACT_RUN: begin
                     cmd.op = cgntt_pkg::OP_NONE;
                  end
                  cgntt_pkg::ACT_READ: begin
                     cmd.op      = cgntt_pkg::OP_CAP_IDX;
                     cmd.rd_en   = 1'b1;
                     cmd.rd_addr = req_index[cgntt_pkg::ADDR_BITS-1:0];
                  end
                  default: cmd.op = cgntt_pkg::OP_NONE;
               endcase
            end
         end
         cgntt_pkg::ST_READ: begin
            if (status.rsp_free) begin
               cmd.op = cgntt_pkg::OP_RSP_LOAD;
            end
         end
         cgntt_pkg::ST_BF_RD_U: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_addr  = u_addr;
            cmd.tw_rd_en = 1'b1;
            cmd.tw_addr  = tw_idx;
         end
         cgntt_pkg::ST_BF_RD_L: begin
            cmd.op      = cgntt_pkg::OP_CAP_UW;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = l_addr;
         end
         cgntt_pkg::ST_BF_CAP_L:    cmd.op = cgntt_pkg::OP_CAP_L;
         cgntt_pkg::ST_BF_RED_U:    cmd.op = cgntt_pkg::OP_RED_U;
         cgntt_pkg::ST_BF_RED_L:    cmd.op = cgntt_pkg::OP_RED_L;
         cgntt_pkg::ST_BF_ADDSUB:   cmd.op = cgntt_pkg::OP_ADDSUB_UL;
         cgntt_pkg::ST_BF_MUL:      cmd.op = dit ? cgntt_pkg::OP_MUL_LW : cgntt_pkg::OP_MUL_DW;
         cgntt_pkg::ST_BF_ADDSUB_T: cmd.op = cgntt_pkg::OP_ADDSUB_UT;
         cgntt_pkg::ST_BF_WR_HI: begin
            cmd.wr_en      = 1'b1;
            cmd.wr_scratch = ~stage_ff[0];
            cmd.wr_addr    = hi_addr;
            cmd.wr_sel     = cgntt_pkg::WR_HI;
         end
         cgntt_pkg::ST_BF_WR_LO: begin
            cmd.wr_en      = 1'b1;
            cmd.wr_scratch = ~stage_ff[0];
            cmd.wr_addr    = lo_addr;
            cmd.wr_sel     = cgntt_pkg::WR_LO;
         end
         cgntt_pkg::ST_INV_S: cmd.op = cgntt_pkg::OP_RED_S;
         cgntt_pkg::ST_INV_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = cnt_ff;
         end
         cgntt_pkg::ST_INV_CAP: cmd.op = cgntt_pkg::OP_CAP_U;
         cgntt_pkg::ST_INV_MUL: cmd.op = cgntt_pkg::OP_MUL_FS;
         cgntt_pkg::ST_INV_WR: begin
            cmd.wr_en      = 1'b1;
            cmd.wr_scratch = final_ff;
            cmd.wr_addr    = cnt_ff;
            cmd.wr_sel     = cgntt_pkg::WR_LO;
         end
         default: cmd.op = cgntt_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cgntt_pkg::ST_IDLE;
         stage_ff  <= '0;
         cnt_ff    <= '0;
         a_mask_ff <= '0;
         b_mask_ff <= '0;
         final_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         stage_ff  <= stage_in;
         cnt_ff    <= cnt_in;
         a_mask_ff <= a_mask_in;
         b_mask_ff <= b_mask_in;
         final_ff  <= final_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/cgntt_dp.sv =====
// ----------------------------------------------------------------------------
// NTT datapath
// Coefficient, scratch and twiddle stores, operand registers, bit-serial
// modular multiplier, add/subtract and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module cgntt_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire cgntt_pkg::dp_cmd_type               cmd,
   output cgntt_pkg::dp_status_type                 status,
   input  wire logic [cgntt_pkg::WORD_BITS-1:0]     modulus,
   input  wire logic [cgntt_pkg::WORD_BITS-1:0]     n_inverse,
   input  wire logic [cgntt_pkg::INDEX_BITS-1:0]    req_index,
   input  wire logic [cgntt_pkg::WORD_BITS-1:0]     req_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [cgntt_pkg::INDEX_BITS-1:0]         rsp_result_index,
   output logic [cgntt_pkg::WORD_BITS-1:0]          rsp_result_value
);

   localparam int W = cgntt_pkg::WORD_BITS;

   function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                            input logic [W-1:0] m);
      logic [W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[W-1:0];
   endfunction

   function automatic logic [W-1:0] sub_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                            input logic [W-1:0] m);
      logic [W:0] d;
      if (a >= b) begin
         d = {1'b0, a} - {1'b0, b};
      end else begin
         d = {1'b0, a} + {1'b0, m} - {1'b0, b};
      end
      return d[W-1:0];
   endfunction

   logic [W-1:0] coef_q, scr_q, tw_q, rd_data, wr_data;
   logic         mod_small;

   logic [W-1:0] u_ff, u_in, l_ff, l_in, w_ff, w_in, s_ff, s_in;
   logic [W-1:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [cgntt_pkg::INDEX_BITS-1:0] idx_ff;

   logic                                 busy_ff, busy_in;
   logic                                 phase_ff, phase_in;
   logic [cgntt_pkg::BIT_CNT_BITS-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [W-1:0]                         acc_ff, acc_in, a_ff, a_in, b_ff, b_in;
   cgntt_pkg::unit_dest_type             dest_ff, dest_in;
   logic [W-1:0]                         step_val;
   logic                                 unit_last;

   logic                                 rsp_valid_ff;
   logic [cgntt_pkg::INDEX_BITS-1:0]     rsp_index_ff;
   logic [W-1:0]                         rsp_value_ff;

   assign mod_small = (modulus[W-1:1] == '0);
   assign rd_data   = cmd.rd_scratch ? scr_q : coef_q;

   always_comb begin
      unique case (cmd.wr_sel)
         cgntt_pkg::WR_LOAD: wr_data = req_value;
         cgntt_pkg::WR_HI:   wr_data = mod_small ? '0 : hi_ff;
         cgntt_pkg::WR_LO:   wr_data = mod_small ? '0 : lo_ff;
         default:            wr_data = req_value;
      endcase
   end

   cgntt_ram #(.WIDTH(W), .DEPTH(cgntt_pkg::LENGTH)) u_coef_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en && !cmd.wr_scratch),
      .wr_addr (cmd.wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en && !cmd.rd_scratch),
      .rd_addr (cmd.rd_addr),
      .rd_data (coef_q)
   );

   cgntt_ram #(.WIDTH(W), .DEPTH(cgntt_pkg::LENGTH)) u_scratch_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en && cmd.wr_scratch),
      .wr_addr (cmd.wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en && cmd.rd_scratch),
      .rd_addr (cmd.rd_addr),
      .rd_data (scr_q)
   );

   cgntt_ram #(.WIDTH(W), .DEPTH(cgntt_pkg::HALF_LEN)) u_twiddle_ram (
      .clock   (clock),
      .wr_en   (cmd.tw_wr_en),
      .wr_addr (cmd.tw_addr),
      .wr_data (req_value),
      .rd_en   (cmd.tw_rd_en),
      .rd_addr (cmd.tw_addr),
      .rd_data (tw_q)
   );

   // bit-serial a*b mod m: double on phase 0, conditional add on phase 1
   always_comb begin
      logic [W:0] dbl, sum;
      dbl = {acc_ff, 1'b0};
      if (dbl >= {1'b0, modulus}) begin
         dbl = dbl - {1'b0, modulus};
      end
      sum = {1'b0, acc_ff} + {1'b0, a_ff};
      if (sum >= {1'b0, modulus}) begin
         sum = sum - {1'b0, modulus};
      end
      if (phase_ff) begin
         step_val = b_ff[W-1] ? sum[W-1:0] : acc_ff;
      end else begin
         step_val = dbl[W-1:0];
      end
   end

   assign unit_last = busy_ff && phase_ff && (bit_cnt_ff == {cgntt_pkg::BIT_CNT_BITS{1'b1}});

   always_comb begin
      busy_in    = busy_ff;
      phase_in   = phase_ff;
      bit_cnt_in = bit_cnt_ff;
      acc_in     = acc_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      dest_in    = dest_ff;
      case (cmd.op)
         cgntt_pkg::OP_RED_U,
         cgntt_pkg::OP_RED_L,
         cgntt_pkg::OP_RED_S,
         cgntt_pkg::OP_MUL_LW,
         cgntt_pkg::OP_MUL_DW,
         cgntt_pkg::OP_MUL_FS: begin
            busy_in    = 1'b1;
            phase_in   = 1'b0;
            bit_cnt_in = '0;
            acc_in     = '0;
         end
         default: begin
            if (busy_ff) begin
               acc_in   = step_val;
               phase_in = ~phase_ff;
               if (phase_ff) begin
                  b_in       = b_ff << 1;
                  bit_cnt_in = bit_cnt_ff + 1'b1;
                  if (unit_last) begin
                     busy_in = 1'b0;
                  end
               end
            end
         end
      endcase
      case (cmd.op)
         cgntt_pkg::OP_RED_U: begin
            a_in = W'(1); b_in = u_ff; dest_in = cgntt_pkg::DEST_U;
         end
         cgntt_pkg::OP_RED_L: begin
            a_in = W'(1); b_in = l_ff; dest_in = cgntt_pkg::DEST_L;
         end
         cgntt_pkg::OP_RED_S: begin
            a_in = W'(1); b_in = n_inverse; dest_in = cgntt_pkg::DEST_S;
         end
         cgntt_pkg::OP_MUL_LW: begin
            a_in = l_ff; b_in = w_ff; dest_in = cgntt_pkg::DEST_LO;
         end
         cgntt_pkg::OP_MUL_DW: begin
            a_in = lo_ff; b_in = w_ff; dest_in = cgntt_pkg::DEST_LO;
         end
         cgntt_pkg::OP_MUL_FS: begin
            a_in = s_ff; b_in = u_ff; dest_in = cgntt_pkg::DEST_LO;
         end
         default: dest_in = dest_ff;
      endcase
   end

   // operand registers
   always_comb begin
      u_in  = u_ff;
      l_in  = l_ff;
      w_in  = w_ff;
      s_in  = s_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      case (cmd.op)
         cgntt_pkg::OP_CAP_UW: begin
            u_in = rd_data;
            w_in = tw_q;
         end
         cgntt_pkg::OP_CAP_U: u_in = rd_data;
         cgntt_pkg::OP_CAP_L: l_in = rd_data;
         cgntt_pkg::OP_ADDSUB_UL: begin
            hi_in = add_mod(u_ff, l_ff, modulus);
            lo_in = sub_mod(u_ff, l_ff, modulus);
         end
         cgntt_pkg::OP_ADDSUB_UT: begin
            hi_in = add_mod(u_ff, lo_ff, modulus);
            lo_in = sub_mod(u_ff, lo_ff, modulus);
         end
         default: hi_in = hi_ff;
      endcase
      if (unit_last) begin
         unique case (dest_ff)
            cgntt_pkg::DEST_U:  u_in  = step_val;
            cgntt_pkg::DEST_L:  l_in  = step_val;
            cgntt_pkg::DEST_S:  s_in  = step_val;
            cgntt_pkg::DEST_LO: lo_in = step_val;
            default:            lo_in = step_val;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      u_ff       <= u_in;
      l_ff       <= l_in;
      w_ff       <= w_in;
      s_ff       <= s_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
      acc_ff     <= acc_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      dest_ff    <= dest_in;
      phase_ff   <= phase_in;
      bit_cnt_ff <= bit_cnt_in;
      if (cmd.op == cgntt_pkg::OP_CAP_IDX) begin
         idx_ff <= req_index;
      end
      if (cmd.op == cgntt_pkg::OP_RSP_LOAD) begin
         rsp_index_ff <= idx_ff;
         rsp_value_ff <= rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         if (cmd.op == cgntt_pkg::OP_RSP_LOAD) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.busy      = busy_ff;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_value = rsp_value_ff;

endmodule

`default_nettype wire

// ===== hdl/constant_geometry_ntt_core.sv =====
// ----------------------------------------------------------------------------
// Constant geometry NTT core
// Load and read items are accepted only while idle; a read result passes the
// store's read register and waits for a free response register. Transform:
// STAGE_COUNT*LENGTH/2 butterflies, plus a scaling pass over every entry in
// inverse mode, both paced by the bit-serial modular multiplier.
// Synchronous reset restores register defaults; stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module constant_geometry_ntt_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   cgntt_req_if.sink                                   req_chan,
   cgntt_rsp_if.source                                 rsp_chan,
   input  wire logic                                   csr_write_en,
   input  wire logic [cgntt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [cgntt_pkg::WORD_BITS-1:0]        csr_wdata
);

   logic [cgntt_pkg::WORD_BITS-1:0]    modulus_ff, n_inverse_ff;
   logic [cgntt_pkg::VARIANT_BITS-1:0] variant_ff;
   logic                               inverse_mode_ff;

   cgntt_pkg::dp_cmd_type    dp_cmd;
   cgntt_pkg::dp_status_type dp_status;
   logic                     req_fire, run_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff      <= cgntt_pkg::MODULUS_RESET;
         n_inverse_ff    <= cgntt_pkg::N_INVERSE_RESET;
         variant_ff      <= '0;
         inverse_mode_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (cgntt_pkg::csr_index_type'(csr_index))
            cgntt_pkg::CSR_MODULUS:      modulus_ff      <= csr_wdata;
            cgntt_pkg::CSR_N_INVERSE:    n_inverse_ff    <= csr_wdata;
            cgntt_pkg::CSR_VARIANT:      variant_ff      <= csr_wdata[cgntt_pkg::VARIANT_BITS-1:0];
            cgntt_pkg::CSR_INVERSE_MODE: inverse_mode_ff <= csr_wdata[0];
            default:                     variant_ff      <= variant_ff;
         endcase
      end
   end

   cgntt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .req_action   (req_chan.action),
      .req_index    (req_chan.index),
      .variant      (variant_ff),
      .inverse_mode (inverse_mode_ff),
      .status       (dp_status),
      .cmd          (dp_cmd)
   );

   cgntt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .modulus          (modulus_ff),
      .n_inverse        (n_inverse_ff),
      .req_index        (req_chan.index),
      .req_value        (req_chan.value),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_result_index (rsp_chan.result_index),
      .rsp_result_value (rsp_chan.result_value)
   );

   assign req_fire = req_chan.valid && req_chan.ready;
   assign run_fire = req_fire && (req_chan.action == cgntt_pkg::ACT_RUN);

   `ASSERT_ALWAYS(a_ready_unit_idle, clock, reset, !req_chan.ready || !dp_status.busy)
   `ASSERT_ALWAYS(a_no_same_ram_rw, clock, reset, !(dp_cmd.wr_en && dp_cmd.rd_en) || (dp_cmd.wr_scratch != dp_cmd.rd_scratch))
   `ASSERT_ALWAYS(a_rsp_load_free, clock, reset, (dp_cmd.op != cgntt_pkg::OP_RSP_LOAD) || dp_status.rsp_free)
   `ASSERT_NEXT(a_run_blocks_req, clock, reset, run_fire, !req_chan.ready)

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant geometry NTT core testbench
// Loads coefficients and twiddles, runs one transform per variant under
// several modulus and scaling settings, and checks every read transfer
// against an in-bench transform model. Sender bursts and receiver stalls
// are random.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      logic [cgntt_pkg::INDEX_BITS-1:0] index;
      logic [cgntt_pkg::WORD_BITS-1:0]  value;
   } readout_type;

   logic clock;
   logic reset;
   logic                                 csr_write_en;
   logic [cgntt_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [cgntt_pkg::WORD_BITS-1:0]      csr_wdata;

   cgntt_req_if req_bus();
   cgntt_rsp_if rsp_bus();

   constant_geometry_ntt_core DUT (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_bus),
      .rsp_chan     (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // model state
   logic [cgntt_pkg::WORD_BITS-1:0] coef_mem [cgntt_pkg::LENGTH];
   logic [cgntt_pkg::WORD_BITS-1:0] scratch_mem [cgntt_pkg::HALF_LEN*2];
   logic [cgntt_pkg::WORD_BITS-1:0] twiddle_mem [cgntt_pkg::HALF_LEN];
   logic                            coef_written [cgntt_pkg::LENGTH];
   logic                            result_in_scratch;
   logic [63:0]                     cfg_modulus;
   logic [63:0]                     cfg_n_inverse;
   logic [1:0]                      cfg_variant;
   logic                            cfg_inverse;

   readout_type pending_reads[$];
   int mismatch_count = 0;
   int burst_left = 0;
   bit long_stall_req = 0;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(64'd80_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic logic [63:0] reduce_word(logic [63:0] x);
      if (cfg_modulus < 2) return 0;
      return x % cfg_modulus;
   endfunction

   function automatic logic [63:0] add_m(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      if (cfg_modulus < 2) return 0;
      s = a + b;
      if (s >= cfg_modulus) s = s - cfg_modulus;
      return s;
   endfunction

   function automatic logic [63:0] sub_m(logic [63:0] a, logic [63:0] b);
      if (cfg_modulus < 2) return 0;
      return (a >= b) ? a - b : a + (cfg_modulus - b);
   endfunction

   function automatic logic [63:0] mul_m(logic [63:0] a, logic [63:0] b);
      if (cfg_modulus < 2) return 0;
      return (a * b) % cfg_modulus;
   endfunction

   function automatic logic [63:0] fetch_word(bit from_scratch, int addr);
      return from_scratch ? 64'(scratch_mem[addr]) : 64'(coef_mem[addr]);
   endfunction

   function automatic void transform_model();
      bit pease, dit, rev, from_scratch;
      logic [31:0] a_mask, b_mask, tw_idx, jr;
      logic [63:0] u, l, w, t, hi, lo;
      pease = !cfg_variant[1];
      dit = cfg_variant[0];
      rev = (pease != dit);
      a_mask = dit ? 0 : cgntt_pkg::HALF_LEN - 1;
      b_mask = dit ? cgntt_pkg::LENGTH >> 2 : cgntt_pkg::HALF_LEN - 1;
      for (int stage = 0; stage < cgntt_pkg::STAGE_COUNT; stage++) begin
         from_scratch = stage[0];
         for (int j = 0; j < cgntt_pkg::HALF_LEN; j++) begin
            if (pease) begin
               u = reduce_word(fetch_word(from_scratch, (2 * j) % cgntt_pkg::LENGTH));
               l = reduce_word(fetch_word(from_scratch, (2 * j + 1) % cgntt_pkg::LENGTH));
            end else begin
               u = reduce_word(fetch_word(from_scratch, j));
               l = reduce_word(fetch_word(from_scratch, j + cgntt_pkg::HALF_LEN));
            end
            jr = 0;
            for (int b = 0; b < cgntt_pkg::STAGE_COUNT - 1; b++) jr = (jr << 1) | ((j >> b) & 1);
            tw_idx = (rev ? jr : j) & a_mask;
            w = reduce_word(64'(twiddle_mem[tw_idx % cgntt_pkg::HALF_LEN]));
            if (dit) begin
               t = mul_m(l, w);
               hi = add_m(u, t);
               lo = sub_m(u, t);
            end else begin
               hi = add_m(u, l);
               lo = mul_m(sub_m(u, l), w);
            end
            if (pease) begin
               if (from_scratch) begin
                  coef_mem[j] = hi[31:0];
                  coef_mem[j + cgntt_pkg::HALF_LEN] = lo[31:0];
               end else begin
                  scratch_mem[j] = hi[31:0];
                  scratch_mem[j + cgntt_pkg::HALF_LEN] = lo[31:0];
               end
            end else begin
               if (from_scratch) begin
                  coef_mem[(2 * j) % cgntt_pkg::LENGTH] = hi[31:0];
                  coef_mem[(2 * j + 1) % cgntt_pkg::LENGTH] = lo[31:0];
               end else begin
                  scratch_mem[(2 * j) % cgntt_pkg::LENGTH] = hi[31:0];
                  scratch_mem[(2 * j + 1) % cgntt_pkg::LENGTH] = lo[31:0];
               end
            end
         end
         if (dit) begin
            a_mask = a_mask | b_mask;
            b_mask = b_mask >> 1;
         end else begin
            a_mask = (a_mask << 1) & b_mask;
         end
      end
      result_in_scratch = (cgntt_pkg::STAGE_COUNT % 2) == 1;
      if (cfg_inverse) begin
         for (int j = 0; j < cgntt_pkg::LENGTH; j++) begin
            if (result_in_scratch)
               scratch_mem[j] = 32'(mul_m(reduce_word(64'(scratch_mem[j])),
                                          reduce_word(cfg_n_inverse)));
            else
               coef_mem[j] = 32'(mul_m(reduce_word(64'(coef_mem[j])),
                                       reduce_word(cfg_n_inverse)));
         end
      end
   endfunction

   function automatic void apply_item(cgntt_pkg::action_type act, logic [7:0] idx,
                                      logic [31:0] val);
      readout_type r;
      case (act)
         cgntt_pkg::ACT_LOAD_COEF: begin
            coef_mem[idx] = val;
            coef_written[idx] = 1;
         end
         cgntt_pkg::ACT_LOAD_TW: twiddle_mem[idx % cgntt_pkg::HALF_LEN] = val;
         cgntt_pkg::ACT_RUN: transform_model();
         default: begin
            r.index = idx;
            r.value = result_in_scratch ? scratch_mem[idx] : coef_mem[idx];
            pending_reads.push_back(r);
         end
      endcase
   endfunction

   task automatic send_item(cgntt_pkg::action_type act, logic [7:0] idx, logic [31:0] val);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
         if (gap > 0) begin
            req_bus.valid <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid  <= 1;
      req_bus.action <= act;
      req_bus.index  <= idx;
      req_bus.value  <= val;
      do begin
         @(negedge clock);
      end while (!req_bus.ready);
      @(posedge clock);
      apply_item(act, idx, val);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(cgntt_pkg::csr_index_type idx, logic [31:0] data);
      csr_write_en <= 1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 0;
      case (idx)
         cgntt_pkg::CSR_MODULUS:   cfg_modulus = 64'(data);
         cgntt_pkg::CSR_N_INVERSE: cfg_n_inverse = 64'(data);
         cgntt_pkg::CSR_VARIANT:   cfg_variant = data[1:0];
         default:                  cfg_inverse = data[0];
      endcase
   endtask

   task automatic read_random_written();
      logic [7:0] idx;
      do idx = 8'($urandom_range(0, 255)); while (!coef_written[idx]);
      send_item(cgntt_pkg::ACT_READ, idx, $urandom);
   endtask

   // reads before any transform, index and value extremes, twiddle index wrap
   task automatic test_directed();
      send_item(cgntt_pkg::ACT_LOAD_COEF, 8'd0, 32'h0000_0000);
      send_item(cgntt_pkg::ACT_LOAD_COEF, 8'd255, 32'hFFFF_FFFF);
      send_item(cgntt_pkg::ACT_LOAD_COEF, 8'd128, 32'h0000_3001);
      send_item(cgntt_pkg::ACT_LOAD_COEF, 8'd127, 32'h8000_0000);
      send_item(cgntt_pkg::ACT_READ, 8'd0, 32'h0);
      send_item(cgntt_pkg::ACT_READ, 8'd255, 32'hFFFF_FFFF);
      send_item(cgntt_pkg::ACT_READ, 8'd128, 32'h0);
      send_item(cgntt_pkg::ACT_READ, 8'd127, 32'h0);
      send_item(cgntt_pkg::ACT_LOAD_TW, 8'd255, 32'h0000_0001);
      send_item(cgntt_pkg::ACT_LOAD_TW, 8'd0, 32'hFFFF_FFFF);
      send_item(cgntt_pkg::ACT_LOAD_COEF, 8'd255, 32'h5555_AAAA);
      send_item(cgntt_pkg::ACT_READ, 8'd255, 32'h0);
      send_item(cgntt_pkg::ACT_LOAD_COEF, 8'd170, 32'hAAAA_5555);
      send_item(cgntt_pkg::ACT_READ, 8'd170, 32'h0);
   endtask

   task automatic test_fill_stores();
      int order[$];
      logic [31:0] val;
      for (int i = 0; i < cgntt_pkg::LENGTH; i++) order.push_back(i);
      order.shuffle();
      foreach (order[i]) begin
         case ($urandom_range(0, 3))
            0: val = $urandom_range(0, 12288);
            1: val = $urandom_range(0, 3);
            default: val = $urandom;
         endcase
         send_item(cgntt_pkg::ACT_LOAD_COEF, 8'(order[i]), val);
      end
      for (int i = 0; i < cgntt_pkg::HALF_LEN; i++)
         send_item(cgntt_pkg::ACT_LOAD_TW,
                   8'(i + cgntt_pkg::HALF_LEN * $urandom_range(0, 1)),
                   ($urandom_range(0, 1) == 0) ? $urandom_range(0, 12288) : $urandom);
   endtask

   task automatic test_variant(logic [1:0] variant, logic [31:0] modulus,
                               logic [31:0] n_inv, logic inverse, bit long_stall);
      wait_idle();
      write_csr(cgntt_pkg::CSR_MODULUS, modulus);
      write_csr(cgntt_pkg::CSR_N_INVERSE, n_inv);
      write_csr(cgntt_pkg::CSR_VARIANT, 32'(variant));
      write_csr(cgntt_pkg::CSR_INVERSE_MODE, 32'(inverse));
      send_item(cgntt_pkg::ACT_RUN, 8'($urandom), $urandom);
      if (long_stall) begin
         // first read is taken once the transform is done
         read_random_written();
         long_stall_req = 1;
         repeat (40) read_random_written();
      end
      for (int i = 0; i < 100; i++) begin
         case ($urandom_range(0, 5))
            0: send_item(cgntt_pkg::ACT_LOAD_COEF, 8'($urandom), $urandom);
            1: send_item(cgntt_pkg::ACT_LOAD_TW, 8'($urandom), $urandom);
            default: read_random_written();
         endcase
      end
   endtask

   // receiver stalls: randomly chosen ready modes, one long hold on request
   initial begin
      int mode, cnt;
      rsp_bus.ready <= 0;
      mode = 0;
      cnt = 0;
      forever begin
         @(posedge clock);
         if (long_stall_req) begin
            rsp_bus.ready <= 0;
            repeat (400) @(posedge clock);
            long_stall_req = 0;
         end
         if (cnt == 0) begin
            mode = $urandom_range(0, 2);
            cnt = 64;
         end
         cnt--;
         case (mode)
            0: rsp_bus.ready <= 1;
            1: rsp_bus.ready <= $urandom_range(0, 1);
            default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(negedge clock) begin
      readout_type exp_r;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_reads.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected read transfer: index %0d value %h",
                        rsp_bus.result_index, rsp_bus.result_value);
         end else begin
            exp_r = pending_reads.pop_front();
            if (rsp_bus.result_index !== exp_r.index ||
                rsp_bus.result_value !== exp_r.value) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("read mismatch: expected %0d/%h, got %0d/%h",
                           exp_r.index, exp_r.value,
                           rsp_bus.result_index, rsp_bus.result_value);
            end
         end
      end
   end

   initial begin
      csr_write_en = 0;
      csr_index = cgntt_pkg::CSR_MODULUS;
      csr_wdata = 0;
      req_bus.valid = 0;
      req_bus.action = cgntt_pkg::ACT_LOAD_COEF;
      req_bus.index = 0;
      req_bus.value = 0;
      reset = 1;
      cfg_modulus = 64'(cgntt_pkg::MODULUS_RESET);
      cfg_n_inverse = 64'(cgntt_pkg::N_INVERSE_RESET);
      cfg_variant = 0;
      cfg_inverse = 0;
      result_in_scratch = 0;
      for (int i = 0; i < cgntt_pkg::LENGTH; i++) coef_written[i] = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      test_directed();
      test_fill_stores();
      test_variant(2'd0, 32'd12289, 32'd1, 1'b0, 1'b0);
      test_variant(2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      test_variant(2'd2, 32'd0, 32'd0, 1'b1, 1'b0);
      test_variant(2'd3, 32'h7FFF_FFFF, 32'd3, 1'b1, 1'b0);

      req_bus.valid <= 0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending_reads.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/cgntt_pkg.sv
hdl/cgntt_req_if.sv
hdl/cgntt_rsp_if.sv
hdl/cgntt_ram.sv
hdl/cgntt_ctrl.sv
hdl/cgntt_dp.sv
hdl/constant_geometry_ntt_core.sv
tb/sv/testbench.sv
